[sv/linked_page_chain_manager_top_assert.svh]
// ----------------------------------------------------------------------------
// Linked page chain manager assertion macros
// Shared property shapes for the concurrent checks of the design.
// ----------------------------------------------------------------------------
`ifndef LINKED_PAGE_CHAIN_MANAGER_TOP_ASSERT_SVH
`define LINKED_PAGE_CHAIN_MANAGER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk and quiet during reset.
`define LPCM_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lpcm check failed: same-cycle implication");

// Next-cycle implication, sampled on clk and quiet during reset.
`define LPCM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lpcm check failed: next-cycle implication");

`endif

[sv/lpcm_pkg.sv]
// ----------------------------------------------------------------------------
// lpcm_pkg
// Constants, codes and the command type shared by the page chain manager.
// ----------------------------------------------------------------------------
package lpcm_pkg;

	localparam int PAGE_COUNT = 4096;
	localparam int PAGE_BYTES = 512;
	localparam int PAGE_SHIFT = 9;
	localparam int PG_W       = 12;
	localparam int HW_W       = 13;
	localparam int OFS_W      = 21;
	localparam int LEN_W      = 15;
	localparam int BYTES_W    = 9;
	localparam int CNT_W      = 7;
	localparam int STEP_W     = 13;
	localparam int MAX_CHAIN  = 64;
	localparam int DATA_BYTES = PAGE_BYTES - 8;
	localparam int DATA_UNITS = DATA_BYTES / 8;
	localparam int RECIP      = 65536 / DATA_UNITS;
	localparam int MAX_LEN    = MAX_CHAIN * DATA_BYTES;

	localparam logic [1:0] MODE_ALLOC = 2'd0;
	localparam logic [1:0] MODE_OVER  = 2'd1;
	localparam logic [1:0] MODE_READ  = 2'd2;
	localparam logic [1:0] MODE_FREE  = 2'd3;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_MISALIGN = 3'd1;
	localparam logic [2:0] ST_ZERO     = 3'd2;
	localparam logic [2:0] ST_EARLY    = 3'd3;
	localparam logic [2:0] ST_FULL     = 3'd4;

	typedef struct packed {
		logic [1:0]       mode;
		logic [PG_W-1:0]  start_pg;
		logic [LEN_W-1:0] len;
		logic [CNT_W-1:0] n;
		logic [2:0]       err;
	} cmd_t;

endpackage

[sv/linked_page_chain_manager_top.sv]
// ----------------------------------------------------------------------------
// linked_page_chain_manager_top
// Manages chains of 512-byte pages with a free list and a fresh-page mark.
// ----------------------------------------------------------------------------
//
// Channel   Handshake                 Payload
// request   start / busy              mode, start_offset, byte_length
// result    valid (one-cycle strobe)  page_offset, next_offset, data_bytes,
//                                     last, status
//
// The front end takes a request when start is high and busy is low, holds
// it in stage registers s1 and s2 while it checks the offset and length and
// works out the page count, and then places it in a two-entry queue.
// The chain engine runs one request at a time. Each link-table access is a
// read with a registered result, so a read or free walk visits each page in
// an A and a B state (free walks the chain twice). Allocate, and overwrite
// when the old chain is too short, count free-list entries in a supply
// check. Overwrite also first counts the old chain and afterwards walks any
// released remainder to its end.
// After reset the free list is empty and page 1 is the first fresh page; the
// link table is not cleared and needs no clearing pass.
// Results cannot be stalled. busy rises when a request is accepted and stays
// high until s2 takes it; s2 cannot take it while s2 waits on a full queue.
// ----------------------------------------------------------------------------
module linked_page_chain_manager_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [1:0]                     mode,
	input  logic [lpcm_pkg::OFS_W-1:0]     start_offset,
	input  logic [lpcm_pkg::LEN_W-1:0]     byte_length,
	output logic                           valid,
	output logic [lpcm_pkg::OFS_W-1:0]     page_offset,
	output logic [lpcm_pkg::OFS_W-1:0]     next_offset,
	output logic [lpcm_pkg::BYTES_W-1:0]   data_bytes,
	output logic                           last,
	output logic [2:0]                     status
);

	// Checked requests travel from the front end to the engine as one struct.
	lpcm_pkg::cmd_t front_cmd;
	lpcm_pkg::cmd_t queue_cmd;
	logic           push;
	logic           pop;
	logic           full;
	logic           empty;

	lpcm_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.mode         (mode),
		.start_offset (start_offset),
		.byte_length  (byte_length),
		.fifo_full    (full),
		.push         (push),
		.cmd          (front_cmd)
	);

	// The queue lets a new request be checked while the engine walks a chain.
	lpcm_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (front_cmd),
		.full   (full),
		.pop    (pop),
		.empty  (empty),
		.dout   (queue_cmd)
	);

	// The engine owns the link table, the free-list head and the fresh mark.
	lpcm_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.empty       (empty),
		.cmd         (queue_cmd),
		.pop         (pop),
		.valid       (valid),
		.page_offset (page_offset),
		.next_offset (next_offset),
		.data_bytes  (data_bytes),
		.last        (last),
		.status      (status)
	);

endmodule

[sv/lpcm_ram.sv]
// ----------------------------------------------------------------------------
// lpcm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lpcm_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[sv/lpcm_front.sv]
// ----------------------------------------------------------------------------
// lpcm_front
// Takes requests, checks them and works out the page count for the back end.
// ----------------------------------------------------------------------------
module lpcm_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   mode,
	input  logic [lpcm_pkg::OFS_W-1:0]   start_offset,
	input  logic [lpcm_pkg::LEN_W-1:0]   byte_length,
	input  logic                         fifo_full,
	output logic                         push,
	output lpcm_pkg::cmd_t               cmd
);

	logic                       s1_valid_q;
	logic [1:0]                 mode_s1;
	logic [lpcm_pkg::OFS_W-1:0] ofs_s1;
	logic [lpcm_pkg::LEN_W-1:0] len_s1;
	logic [12:0]                x_s1;
	logic [23:0]                prod_s1;
	logic                       s2_valid_q;
	lpcm_pkg::cmd_t             cmd_s2;

	logic [15:0] y_d;
	logic [12:0] x_d;
	logic [23:0] prod_d;
	logic [7:0]  q0;
	logic [13:0] m63;
	logic [13:0] r63;
	logic [7:0]  n_d;
	logic [lpcm_pkg::PG_W-1:0] pg_d;
	logic [2:0]  err_d;
	logic        accept;
	logic        load_s2;

	// Ceiling of length over 504 as the floor of (length + 503) / 8 / 63,
	// by reciprocal multiply and one correction step.
	assign y_d    = {1'b0, byte_length} + 16'(lpcm_pkg::DATA_BYTES - 1);
	assign x_d    = y_d[15:3];
	assign prod_d = 24'(x_d) * 24'(lpcm_pkg::RECIP);

	assign q0  = prod_s1[23:16];
	assign m63 = {q0, 6'b0} - {6'b0, q0};
	assign r63 = {1'b0, x_s1} - m63;
	assign n_d = (r63 >= 14'(lpcm_pkg::DATA_UNITS)) ? q0 + 8'd1 : q0;
	assign pg_d = ofs_s1[lpcm_pkg::OFS_W-1:lpcm_pkg::PAGE_SHIFT];

	always_comb begin
		err_d = lpcm_pkg::ST_OK;
		if (mode_s1 != lpcm_pkg::MODE_ALLOC &&
		    (ofs_s1[lpcm_pkg::PAGE_SHIFT-1:0] != '0 || pg_d == '0)) begin
			err_d = lpcm_pkg::ST_MISALIGN;
		end else if (mode_s1 == lpcm_pkg::MODE_FREE) begin
			err_d = lpcm_pkg::ST_OK;
		end else if (len_s1 == '0) begin
			err_d = lpcm_pkg::ST_ZERO;
		end else if (len_s1 > lpcm_pkg::LEN_W'(lpcm_pkg::MAX_LEN)) begin
			err_d = lpcm_pkg::ST_FULL;
		end
	end

	assign accept  = start && !s1_valid_q;
	assign busy    = s1_valid_q;
	assign push    = s2_valid_q && !fifo_full;
	assign load_s2 = s1_valid_q && (!s2_valid_q || push);
	assign cmd     = cmd_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			s2_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (load_s2) begin
				s1_valid_q <= 1'b0;
			end
			if (load_s2) begin
				s2_valid_q <= 1'b1;
			end else if (push) begin
				s2_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1 <= mode;
			ofs_s1  <= start_offset;
			len_s1  <= byte_length;
			x_s1    <= x_d;
			prod_s1 <= prod_d;
		end
		if (load_s2) begin
			cmd_s2.mode     <= mode_s1;
			cmd_s2.start_pg <= pg_d;
			cmd_s2.len      <= len_s1;
			cmd_s2.n        <= n_d[lpcm_pkg::CNT_W-1:0];
			cmd_s2.err      <= err_d;
		end
	end

endmodule

[sv/lpcm_fifo.sv]
// ----------------------------------------------------------------------------
// lpcm_fifo
// Two-entry command queue between the front end and the chain engine.
// ----------------------------------------------------------------------------
module lpcm_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  lpcm_pkg::cmd_t din,
	output logic           full,
	input  logic           pop,
	output logic           empty,
	output lpcm_pkg::cmd_t dout
);

	lpcm_pkg::cmd_t entry_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;

	assign full  = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign dout  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= din;
		end
	end

endmodule

[sv/lpcm_back.sv]
// ----------------------------------------------------------------------------
// lpcm_back
// Chain engine: walks, builds, rewrites and frees chains in the link table.
// ----------------------------------------------------------------------------
`include "linked_page_chain_manager_top_assert.svh"

module lpcm_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           empty,
	input  lpcm_pkg::cmd_t                 cmd,
	output logic                           pop,
	output logic                           valid,
	output logic [lpcm_pkg::OFS_W-1:0]     page_offset,
	output logic [lpcm_pkg::OFS_W-1:0]     next_offset,
	output logic [lpcm_pkg::BYTES_W-1:0]   data_bytes,
	output logic                           last,
	output logic [2:0]                     status
);

	localparam int PW = lpcm_pkg::PG_W;
	localparam int CW = lpcm_pkg::CNT_W;

	typedef enum logic [19:0] {
		S_IDLE    = 20'h00001,
		S_RD_A    = 20'h00002,
		S_RD_B    = 20'h00004,
		S_FR1_A   = 20'h00008,
		S_FR1_B   = 20'h00010,
		S_FR2_A   = 20'h00020,
		S_FR2_B   = 20'h00040,
		S_SUP     = 20'h00080,
		S_SUP_B   = 20'h00100,
		S_TK      = 20'h00200,
		S_TK_W    = 20'h00400,
		S_AL_STEP = 20'h00800,
		S_AL_EMIT = 20'h01000,
		S_OW_CA   = 20'h02000,
		S_OW_CB   = 20'h04000,
		S_OW_A    = 20'h08000,
		S_OW_B    = 20'h10000,
		S_OW_EMIT = 20'h20000,
		S_TL_A    = 20'h40000,
		S_TL_B    = 20'h80000
	} state_t;

	typedef enum logic [1:0] {
		RET_AL_FIRST = 2'd0,
		RET_AL_NEXT  = 2'd1,
		RET_OW       = 2'd2
	} ret_t;

	state_t                        state_q;
	ret_t                          ret_q;
	logic [1:0]                    mode_q;
	logic [PW-1:0]                 start_q;
	logic [lpcm_pkg::LEN_W-1:0]    len_q;
	logic [lpcm_pkg::LEN_W-1:0]    rem_q;
	logic [CW-1:0]                 n_q;
	logic [CW-1:0]                 idx_q;
	logic [CW-1:0]                 cnt_q;
	logic [CW-1:0]                 need_q;
	logic [CW-1:0]                 sup_cnt_q;
	logic [PW-1:0]                 sup_c_q;
	logic [PW-1:0]                 cur_q;
	logic [PW-1:0]                 nxt_q;
	logic [PW-1:0]                 old_q;
	logic [PW-1:0]                 tail_q;
	logic [PW-1:0]                 tl_c_q;
	logic [lpcm_pkg::STEP_W-1:0]   steps_q;
	logic                          ext_q;
	logic                          fr_ok_q;
	logic [PW-1:0]                 free_head_q;
	logic [lpcm_pkg::HW_W-1:0]     hw_q;

	logic                          valid_q;
	logic [PW-1:0]                 opage_q;
	logic [PW-1:0]                 onext_q;
	logic [lpcm_pkg::BYTES_W-1:0]  obytes_q;
	logic                          olast_q;
	logic [2:0]                    ostat_q;

	logic                          we;
	logic [PW-1:0]                 waddr;
	logic [PW-1:0]                 wdata;
	logic [PW-1:0]                 raddr;
	logic [PW-1:0]                 rdata;

	logic [lpcm_pkg::BYTES_W-1:0]  rem_b;
	logic [lpcm_pkg::LEN_W-1:0]    rem_after;
	logic                          is_last;
	logic                          hw_room;
	logic [lpcm_pkg::HW_W-1:0]     fresh;
	logic                          sup_ok;
	logic                          tk_done;
	logic [PW-1:0]                 tk_page;
	logic [PW-1:0]                 old_v;

	lpcm_ram #(
		.WIDTH (PW),
		.DEPTH (lpcm_pkg::PAGE_COUNT)
	) u_links (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign rem_b = (rem_q > lpcm_pkg::LEN_W'(lpcm_pkg::DATA_BYTES)) ?
	               lpcm_pkg::BYTES_W'(lpcm_pkg::DATA_BYTES) : rem_q[lpcm_pkg::BYTES_W-1:0];
	assign rem_after = rem_q - lpcm_pkg::LEN_W'(rem_b);
	assign is_last   = ({1'b0, idx_q} + 8'd1) == {1'b0, n_q};
	assign hw_room   = hw_q < lpcm_pkg::HW_W'(lpcm_pkg::PAGE_COUNT);
	assign fresh     = hw_room ? lpcm_pkg::HW_W'(lpcm_pkg::PAGE_COUNT) - hw_q : '0;
	assign sup_ok    = (14'(sup_cnt_q) + 14'(fresh)) >= 14'(need_q);
	assign tk_done   = (state_q == S_TK && free_head_q == '0) || state_q == S_TK_W;
	assign tk_page   = (state_q == S_TK_W) ? free_head_q : (hw_room ? hw_q[PW-1:0] : '0);
	assign old_v     = ext_q ? old_q : rdata;
	assign pop       = (state_q == S_IDLE) && !empty;

	always_comb begin
		unique case (state_q)
			S_SUP:   raddr = sup_c_q;
			S_TK:    raddr = free_head_q;
			S_TL_A:  raddr = tl_c_q;
			default: raddr = cur_q;
		endcase
	end

	always_comb begin
		we    = 1'b0;
		waddr = cur_q;
		wdata = nxt_q;
		unique case (state_q)
			S_AL_EMIT, S_OW_EMIT: we = 1'b1;
			S_FR2_B: begin
				we    = fr_ok_q && is_last;
				wdata = free_head_q;
			end
			S_TL_B: begin
				we    = (rdata == '0);
				waddr = tl_c_q;
				wdata = free_head_q;
			end
			default: we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ret_q       <= RET_AL_FIRST;
			free_head_q <= '0;
			hw_q        <= lpcm_pkg::HW_W'(1);
			valid_q     <= 1'b0;
			mode_q      <= lpcm_pkg::MODE_ALLOC;
			start_q     <= '0;
			len_q       <= '0;
			rem_q       <= '0;
			n_q         <= '0;
			idx_q       <= '0;
			cnt_q       <= '0;
			need_q      <= '0;
			sup_cnt_q   <= '0;
			sup_c_q     <= '0;
			cur_q       <= '0;
			nxt_q       <= '0;
			old_q       <= '0;
			tail_q      <= '0;
			tl_c_q      <= '0;
			steps_q     <= '0;
			ext_q       <= 1'b0;
			fr_ok_q     <= 1'b0;
			opage_q     <= '0;
			onext_q     <= '0;
			obytes_q    <= '0;
			olast_q     <= 1'b0;
			ostat_q     <= lpcm_pkg::ST_OK;
		end else begin
			valid_q <= 1'b0;
			if (tk_done) begin
				if (state_q == S_TK_W) begin
					free_head_q <= rdata;
				end else if (hw_room) begin
					hw_q <= hw_q + lpcm_pkg::HW_W'(1);
				end
			end
			unique case (state_q)
				S_IDLE: begin
					if (!empty) begin
						mode_q  <= cmd.mode;
						start_q <= cmd.start_pg;
						len_q   <= cmd.len;
						rem_q   <= cmd.len;
						n_q     <= cmd.n;
						need_q  <= cmd.n;
						idx_q   <= '0;
						cur_q   <= cmd.start_pg;
						if (cmd.err != lpcm_pkg::ST_OK) begin
							valid_q  <= 1'b1;
							opage_q  <= '0;
							onext_q  <= '0;
							obytes_q <= '0;
							olast_q  <= 1'b1;
							ostat_q  <= cmd.err;
						end else begin
							unique case (cmd.mode)
								lpcm_pkg::MODE_READ: state_q <= S_RD_A;
								lpcm_pkg::MODE_FREE: begin
									cnt_q   <= CW'(1);
									state_q <= S_FR1_A;
								end
								lpcm_pkg::MODE_ALLOC: begin
									sup_c_q   <= free_head_q;
									sup_cnt_q <= '0;
									state_q   <= S_SUP;
								end
								default: begin
									cnt_q   <= CW'(1);
									state_q <= S_OW_CA;
								end
							endcase
						end
					end
				end
				S_RD_A: state_q <= S_RD_B;
				S_RD_B: begin
					valid_q  <= 1'b1;
					opage_q  <= cur_q;
					obytes_q <= rem_b;
					rem_q    <= rem_after;
					if (rem_after != '0 && rdata == '0) begin
						onext_q <= '0;
						olast_q <= 1'b1;
						ostat_q <= lpcm_pkg::ST_EARLY;
						state_q <= S_IDLE;
					end else begin
						onext_q <= rdata;
						olast_q <= is_last;
						ostat_q <= lpcm_pkg::ST_OK;
						cur_q   <= rdata;
						idx_q   <= idx_q + CW'(1);
						state_q <= is_last ? S_IDLE : S_RD_A;
					end
				end
				S_FR1_A: state_q <= S_FR1_B;
				S_FR1_B: begin
					if (rdata == '0 || cnt_q >= CW'(lpcm_pkg::MAX_CHAIN)) begin
						fr_ok_q <= (rdata == '0);
						n_q     <= cnt_q;
						cur_q   <= start_q;
						idx_q   <= '0;
						state_q <= S_FR2_A;
					end else begin
						cur_q   <= rdata;
						cnt_q   <= cnt_q + CW'(1);
						state_q <= S_FR1_A;
					end
				end
				S_FR2_A: state_q <= S_FR2_B;
				S_FR2_B: begin
					valid_q  <= 1'b1;
					opage_q  <= cur_q;
					obytes_q <= '0;
					olast_q  <= is_last;
					if (fr_ok_q && is_last) begin
						onext_q     <= free_head_q;
						ostat_q     <= lpcm_pkg::ST_OK;
						free_head_q <= start_q;
						state_q     <= S_IDLE;
					end else begin
						onext_q <= rdata;
						ostat_q <= is_last ? lpcm_pkg::ST_EARLY : lpcm_pkg::ST_OK;
						cur_q   <= rdata;
						idx_q   <= idx_q + CW'(1);
						state_q <= is_last ? S_IDLE : S_FR2_A;
					end
				end
				S_SUP: begin
					if (sup_c_q != '0 && sup_cnt_q < need_q) begin
						state_q <= S_SUP_B;
					end else if (!sup_ok) begin
						valid_q  <= 1'b1;
						opage_q  <= '0;
						onext_q  <= '0;
						obytes_q <= '0;
						olast_q  <= 1'b1;
						ostat_q  <= lpcm_pkg::ST_FULL;
						state_q  <= S_IDLE;
					end else if (mode_q == lpcm_pkg::MODE_ALLOC) begin
						idx_q   <= '0;
						rem_q   <= len_q;
						ret_q   <= RET_AL_FIRST;
						state_q <= S_TK;
					end else begin
						cur_q   <= start_q;
						idx_q   <= '0;
						rem_q   <= len_q;
						ext_q   <= 1'b0;
						tail_q  <= '0;
						state_q <= S_OW_A;
					end
				end
				S_SUP_B: begin
					sup_c_q   <= rdata;
					sup_cnt_q <= sup_cnt_q + CW'(1);
					state_q   <= S_SUP;
				end
				S_TK, S_TK_W: begin
					if (!tk_done) begin
						state_q <= S_TK_W;
					end else begin
						unique case (ret_q)
							RET_AL_FIRST: begin
								cur_q   <= tk_page;
								state_q <= S_AL_STEP;
							end
							RET_AL_NEXT: begin
								nxt_q   <= tk_page;
								state_q <= S_AL_EMIT;
							end
							default: begin
								nxt_q   <= tk_page;
								ext_q   <= 1'b1;
								state_q <= S_OW_EMIT;
							end
						endcase
					end
				end
				S_AL_STEP: begin
					if (!is_last) begin
						ret_q   <= RET_AL_NEXT;
						state_q <= S_TK;
					end else begin
						nxt_q   <= '0;
						state_q <= S_AL_EMIT;
					end
				end
				S_AL_EMIT, S_OW_EMIT: begin
					valid_q  <= 1'b1;
					opage_q  <= cur_q;
					onext_q  <= nxt_q;
					obytes_q <= rem_b;
					olast_q  <= is_last;
					ostat_q  <= lpcm_pkg::ST_OK;
					rem_q    <= rem_after;
					cur_q    <= nxt_q;
					idx_q    <= idx_q + CW'(1);
					if (!is_last) begin
						state_q <= (state_q == S_AL_EMIT) ? S_AL_STEP : S_OW_A;
					end else if (state_q == S_OW_EMIT && tail_q != '0) begin
						tl_c_q  <= tail_q;
						steps_q <= '0;
						state_q <= S_TL_A;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_OW_CA: begin
					if (cnt_q < n_q) begin
						state_q <= S_OW_CB;
					end else begin
						cur_q   <= start_q;
						idx_q   <= '0;
						rem_q   <= len_q;
						ext_q   <= 1'b0;
						tail_q  <= '0;
						state_q <= S_OW_A;
					end
				end
				S_OW_CB: begin
					if (rdata != '0) begin
						cur_q   <= rdata;
						cnt_q   <= cnt_q + CW'(1);
						state_q <= S_OW_CA;
					end else begin
						need_q    <= n_q - cnt_q;
						sup_c_q   <= free_head_q;
						sup_cnt_q <= '0;
						state_q   <= S_SUP;
					end
				end
				S_OW_A: state_q <= S_OW_B;
				S_OW_B: begin
					old_q <= old_v;
					if (is_last) begin
						nxt_q   <= '0;
						tail_q  <= ext_q ? '0 : old_v;
						state_q <= S_OW_EMIT;
					end else if (!ext_q && old_v != '0) begin
						nxt_q   <= old_v;
						state_q <= S_OW_EMIT;
					end else begin
						ret_q   <= RET_OW;
						state_q <= S_TK;
					end
				end
				S_TL_A: state_q <= S_TL_B;
				S_TL_B: begin
					if (rdata == '0) begin
						free_head_q <= tail_q;
						state_q     <= S_IDLE;
					end else if (steps_q < lpcm_pkg::STEP_W'(lpcm_pkg::PAGE_COUNT)) begin
						tl_c_q  <= rdata;
						steps_q <= steps_q + lpcm_pkg::STEP_W'(1);
						state_q <= S_TL_A;
					end else begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign valid       = valid_q;
	assign page_offset = {opage_q, {lpcm_pkg::PAGE_SHIFT{1'b0}}};
	assign next_offset = {onext_q, {lpcm_pkg::PAGE_SHIFT{1'b0}}};
	assign data_bytes  = obytes_q;
	assign last        = olast_q;
	assign status      = ostat_q;

	// A result that is not the last one leaves the engine still working.
	`LPCM_ASSERT_NOW(a_nonlast_busy, valid_q && !olast_q, state_q != S_IDLE)
	// Every error result closes its request.
	`LPCM_ASSERT_NOW(a_err_is_last, valid_q && ostat_q != lpcm_pkg::ST_OK, olast_q)
	// The fresh-page mark never runs past the end of the store.
	`LPCM_ASSERT_NOW(a_hw_bound, 1'b1, hw_q <= lpcm_pkg::HW_W'(lpcm_pkg::PAGE_COUNT))
	// Requests are taken from the queue only while idle, and one without an error moves the engine out of idle.
	`LPCM_ASSERT_NEXT(a_pop_leaves_idle, pop && cmd.err == lpcm_pkg::ST_OK, state_q != S_IDLE)

endmodule
